### rtl/olhtd_pkg.sv
package olhtd_pkg;

  localparam int DEPTH = 32;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VW    = 32;
  localparam int PW    = 6;
  localparam int KW    = 2;
  localparam int IW    = (CW > PW) ? CW : PW;

  localparam logic [KW-1:0] KIND_FRONT  = 2'd0;
  localparam logic [KW-1:0] KIND_BACK   = 2'd1;
  localparam logic [KW-1:0] KIND_DELETE = 2'd2;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LATCH,
    DP_PUSH_FRONT,
    DP_PUSH_BACK,
    DP_DEL_START,
    DP_DEL_STEP,
    DP_LIST_START,
    DP_LIST
  } dp_op_t;

  typedef struct packed {
    logic shift_done;
    logic list_done;
  } dp_status_t;

  // Ring position of a logical offset from the head.
  function automatic logic [AW-1:0] ring_add(logic [AW-1:0] base, logic [CW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(ofs);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ring_dec(logic [AW-1:0] a);
    logic [AW-1:0] r;
    if (a == '0) r = AW'(DEPTH - 1);
    else r = a - AW'(1);
    return r;
  endfunction

endpackage

### rtl/olhtd_ram.sv
module olhtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/olhtd_ctrl.sv
module olhtd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [olhtd_pkg::KW-1:0]    in_kind,
  output logic                        in_stall,
  input  olhtd_pkg::dp_status_t       status,
  output olhtd_pkg::dp_op_t           op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_LIST_START,
    S_LIST
  } state_t;

  state_t                     state_r, state_nxt;
  logic [olhtd_pkg::KW-1:0]   kind_r, kind_nxt;

  // Hold off the sender while in reset, so no word is taken and then lost.
  assign in_stall = (state_r != S_IDLE) || !rst_n;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    op        = olhtd_pkg::DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = olhtd_pkg::DP_LATCH;
          kind_nxt  = in_kind;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (kind_r)
          olhtd_pkg::KIND_FRONT: begin
            op        = olhtd_pkg::DP_PUSH_FRONT;
            state_nxt = S_LIST_START;
          end
          olhtd_pkg::KIND_BACK: begin
            op        = olhtd_pkg::DP_PUSH_BACK;
            state_nxt = S_LIST_START;
          end
          olhtd_pkg::KIND_DELETE: begin
            op        = olhtd_pkg::DP_DEL_START;
            state_nxt = S_SHIFT;
          end
          default: begin
            state_nxt = S_LIST_START;
          end
        endcase
      end
      S_SHIFT: begin
        op = olhtd_pkg::DP_DEL_STEP;
        if (status.shift_done) state_nxt = S_LIST_START;
      end
      S_LIST_START: begin
        op        = olhtd_pkg::DP_LIST_START;
        state_nxt = S_LIST;
      end
      S_LIST: begin
        op = olhtd_pkg::DP_LIST;
        if (status.list_done) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    kind_r <= kind_nxt;
  end

endmodule

### rtl/olhtd_dp.sv
module olhtd_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  olhtd_pkg::dp_op_t           op,
  output olhtd_pkg::dp_status_t       status,
  input  logic [olhtd_pkg::VW-1:0]    in_value,
  input  logic [olhtd_pkg::PW-1:0]    in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [olhtd_pkg::VW-1:0]    out_element,
  output logic                        out_last,
  output logic                        out_empty_res,
  output logic                        out_dropped
);

  localparam int AW = olhtd_pkg::AW;
  localparam int CW = olhtd_pkg::CW;
  localparam int IW = olhtd_pkg::IW;

  logic [AW-1:0]               head_r, head_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic [olhtd_pkg::VW-1:0]    value_r, value_nxt;
  logic [olhtd_pkg::PW-1:0]    pos_r, pos_nxt;
  logic                        dropped_r, dropped_nxt;
  logic                        del_ok_r, del_ok_nxt;
  logic                        wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]               wr_addr_r, wr_addr_nxt;
  logic [AW-1:0]               held_addr_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        last_r, last_nxt;
  logic                        empty_r, empty_nxt;

  logic                        full;
  logic                        del_ok;
  logic                        advance;
  logic                        idx_lt;
  logic                        shift_done;
  logic [IW-1:0]               pos_ext;
  logic [AW-1:0]               rd_addr;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [olhtd_pkg::VW-1:0]    ram_wdata;
  logic [olhtd_pkg::VW-1:0]    ram_rdata;

  assign full       = (count_r == CW'(olhtd_pkg::DEPTH));
  assign pos_ext    = IW'(pos_r);
  assign del_ok     = (pos_ext < IW'(count_r));
  assign advance    = !out_valid_r || !out_stall;
  assign idx_lt     = (idx_r < count_r);
  assign shift_done = !idx_lt && !wr_pend_r;

  assign status.shift_done = shift_done;
  assign status.list_done  = (op == olhtd_pkg::DP_LIST) && out_valid_r && last_r && !out_stall;

  // Hold the read address while a listed word is stalled, so the RAM keeps presenting it.
  always_comb begin
    if (op == olhtd_pkg::DP_LIST && !advance) rd_addr = held_addr_r;
    else rd_addr = olhtd_pkg::ring_add(head_r, idx_r);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_r;
    ram_wdata = ram_rdata;
    if (op == olhtd_pkg::DP_PUSH_FRONT && !full) begin
      ram_we    = 1'b1;
      ram_waddr = olhtd_pkg::ring_dec(head_r);
      ram_wdata = value_r;
    end else if (op == olhtd_pkg::DP_PUSH_BACK && !full) begin
      ram_we    = 1'b1;
      ram_waddr = olhtd_pkg::ring_add(head_r, count_r);
      ram_wdata = value_r;
    end else if (wr_pend_r) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    value_nxt     = value_r;
    pos_nxt       = pos_r;
    dropped_nxt   = dropped_r;
    del_ok_nxt    = del_ok_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    out_valid_nxt = out_valid_r;
    last_nxt      = last_r;
    empty_nxt     = empty_r;
    case (op)
      olhtd_pkg::DP_LATCH: begin
        value_nxt   = in_value;
        pos_nxt     = in_position;
        dropped_nxt = 1'b0;
      end
      olhtd_pkg::DP_PUSH_FRONT: begin
        if (full) begin
          dropped_nxt = 1'b1;
        end else begin
          head_nxt  = olhtd_pkg::ring_dec(head_r);
          count_nxt = count_r + CW'(1);
        end
      end
      olhtd_pkg::DP_PUSH_BACK: begin
        if (full) dropped_nxt = 1'b1;
        else count_nxt = count_r + CW'(1);
      end
      olhtd_pkg::DP_DEL_START: begin
        del_ok_nxt = del_ok;
        if (del_ok) idx_nxt = pos_ext[CW-1:0] + CW'(1);
        else idx_nxt = count_r;
      end
      olhtd_pkg::DP_DEL_STEP: begin
        // Read one word ahead and write it one place towards the front next cycle.
        if (idx_lt) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = olhtd_pkg::ring_dec(rd_addr);
          idx_nxt     = idx_r + CW'(1);
        end
        if (shift_done && del_ok_r) begin
          count_nxt  = count_r - CW'(1);
          del_ok_nxt = 1'b0;
        end
      end
      olhtd_pkg::DP_LIST_START: begin
        if (count_r == '0) begin
          out_valid_nxt = 1'b1;
          last_nxt      = 1'b1;
          empty_nxt     = 1'b1;
          idx_nxt       = CW'(1);
        end else begin
          out_valid_nxt = 1'b0;
          empty_nxt     = 1'b0;
          idx_nxt       = '0;
        end
      end
      olhtd_pkg::DP_LIST: begin
        if (advance) begin
          if (idx_lt) begin
            out_valid_nxt = 1'b1;
            last_nxt      = (({1'b0, idx_r} + (CW+1)'(1)) == {1'b0, count_r});
            empty_nxt     = 1'b0;
            idx_nxt       = idx_r + CW'(1);
          end else begin
            out_valid_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      del_ok_r    <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      del_ok_r    <= del_ok_nxt;
    end
    idx_r       <= idx_nxt;
    value_r     <= value_nxt;
    pos_r       <= pos_nxt;
    dropped_r   <= dropped_nxt;
    wr_addr_r   <= wr_addr_nxt;
    held_addr_r <= rd_addr;
    last_r      <= last_nxt;
    empty_r     <= empty_nxt;
  end

  olhtd_ram #(
    .WIDTH (olhtd_pkg::VW),
    .DEPTH (olhtd_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_element   = empty_r ? '0 : ram_rdata;
  assign out_last      = last_r;
  assign out_empty_res = empty_r;
  assign out_dropped   = dropped_r;

endmodule

### rtl/ordered_list_head_tail_delete_core.sv
// channel | direction | handshake           | word
// in_     | input     | in_valid / in_stall   | kind, value, position
// out_    | output    | out_valid / out_stall | element, last, empty_res, dropped
//
// Insert, append or unused kind: after acceptance the listing gives one word per cycle while
// out_stall is low; an empty listing gives its single word. A delete at p first moves each
// entry behind p one place towards the front (none when p is the last entry or out of range).
// The list sits in a ring in one RAM; insert at front is one write.
// Synchronous active-low reset empties the list and raises in_stall; RAM contents are kept.
// A stalled word holds by re-reading its RAM address; in_stall falls after the last word.
module ordered_list_head_tail_delete_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [olhtd_pkg::KW-1:0]   in_kind,
  input  logic signed [olhtd_pkg::VW-1:0]   in_value,
  input  logic        [olhtd_pkg::PW-1:0]   in_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [olhtd_pkg::VW-1:0]   out_element,
  output logic                              out_last,
  output logic                              out_empty_res,
  output logic                              out_dropped
);

  olhtd_pkg::dp_op_t          op;
  olhtd_pkg::dp_status_t      status;
  logic [olhtd_pkg::VW-1:0]   element;

  olhtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .op       (op)
  );

  olhtd_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .status        (status),
    .in_value      ($unsigned(in_value)),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_element   (element),
    .out_last      (out_last),
    .out_empty_res (out_empty_res),
    .out_dropped   (out_dropped)
  );

  assign out_element = $signed(element);

endmodule
